[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/swfd_pkg.sv]
// Types, constants and the CRC step for the sync-word deframer.
// No dependencies.
package swfd_pkg;

   localparam int FRAME_STORE_DEPTH = 4096;
   localparam int ADDR_W = $clog2(FRAME_STORE_DEPTH);
   localparam int CNT_W = $clog2(FRAME_STORE_DEPTH + 1);
   localparam int FP_W = 12;
   localparam int MAX_RESULTS = 64;
   localparam int NRES_W = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] SYNC_FIRST = 8'hEB;
   localparam logic [7:0] SYNC_SECOND = 8'h90;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_CRC_ERR = 2'd2,
      KIND_TRUNC   = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      PH_HUNT    = 7'b0000001,
      PH_SYNC2   = 7'b0000010,
      PH_HDR0    = 7'b0000100,
      PH_HDR1    = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_CRC0    = 7'b0100000,
      PH_CRC1    = 7'b1000000
   } phase_type;

   typedef enum logic [3:0] {
      SQ_IDLE  = 4'b0001,
      SQ_RUN   = 4'b0010,
      SQ_EXEC  = 4'b0100,
      SQ_TRUNC = 4'b1000
   } seq_type;

   typedef struct packed {
      logic              wr_req;
      logic [7:0]        wr_data;
      logic              wr_eos;
      logic              rd_req;
      logic              rewind;
      logic [FP_W-1:0]   rewind_len;
      logic [FP_W-1:0]   retained;
   } store_cmd_type;

   typedef struct packed {
      logic [7:0] rd_data;
      logic       rd_end;
      logic       empty;
   } store_stat_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[hw/rtl/swfd_if.sv]
// Channel interfaces for the deframer: byte requests and result responses.
// Depends on swfd_pkg.
interface swfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;
   modport source (output valid, data_byte, end_of_stream, input ready);
   modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface swfd_rsp_if import swfd_pkg::*;;
   logic             valid;
   logic             ready;
   kind_type         kind;
   logic [6:0]       frame_id;
   logic [10:0]      payload_length;
   logic [7:0]       payload_byte;
   logic [10:0]      byte_index;
   logic [15:0]      crc_received;
   logic [15:0]      crc_computed;
   logic [31:0]      valid_total;
   logic [31:0]      error_total;
   logic             last;
   modport source (output valid, kind, frame_id, payload_length, payload_byte, byte_index,
                   crc_received, crc_computed, valid_total, error_total, last,
                   input ready);
   modport sink (input valid, kind, frame_id, payload_length, payload_byte, byte_index,
                 crc_received, crc_computed, valid_total, error_total, last,
                 output ready);
   modport mon (input valid, ready, kind, frame_id, payload_length, payload_byte,
                byte_index, crc_received, crc_computed, valid_total, error_total, last);
endinterface

[hw/rtl/swfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/swfd_store.sv]
// Circular frame store: byte and end-mark RAMs with write and read pointers; a rewind moves the read pointer back.
// Depends on swfd_pkg and swfd_ram.
module swfd_store import swfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  store_cmd_type  cmd,
   output store_stat_type stat
);
   logic [ADDR_W-1:0] wa_ff, wa_in, ra_ff, ra_in, wa_prev, ra_next;
   logic [CNT_W-1:0]  pend_ff, pend_in;
   logic [CNT_W:0]    fill;
   logic              full, data_we, mark_we, mark_wdata;
   logic [ADDR_W-1:0] mark_addr;
   logic [ADDR_W:0]   diff;

   assign fill = (CNT_W+1)'(pend_ff) + (CNT_W+1)'(cmd.retained);
   assign full = fill >= (CNT_W+1)'(FRAME_STORE_DEPTH);
   assign wa_prev = (wa_ff == '0) ? ADDR_W'(FRAME_STORE_DEPTH - 1) : wa_ff - 1'b1;
   assign ra_next = (ra_ff == ADDR_W'(FRAME_STORE_DEPTH - 1)) ? '0 : ra_ff + 1'b1;
   assign diff = {1'b0, ra_ff} - (ADDR_W+1)'(cmd.rewind_len);

   assign data_we = cmd.wr_req && !full;
   assign mark_we = cmd.wr_req && (!full || cmd.wr_eos);
   assign mark_addr = full ? wa_prev : wa_ff;
   assign mark_wdata = full ? 1'b1 : cmd.wr_eos;

   always_comb begin
      wa_in = wa_ff;
      ra_in = ra_ff;
      pend_in = pend_ff;
      if (data_we) begin
         wa_in = (wa_ff == ADDR_W'(FRAME_STORE_DEPTH - 1)) ? '0 : wa_ff + 1'b1;
         pend_in = pend_ff + 1'b1;
      end
      if (cmd.rd_req) begin
         ra_in = ra_next;
         pend_in = pend_ff - 1'b1;
      end
      if (cmd.rewind) begin
         ra_in = diff[ADDR_W] ? ADDR_W'(diff + (ADDR_W+1)'(FRAME_STORE_DEPTH))
                              : diff[ADDR_W-1:0];
         pend_in = pend_ff + CNT_W'(cmd.rewind_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wa_ff <= '0;
         ra_ff <= '0;
         pend_ff <= '0;
      end else begin
         wa_ff <= wa_in;
         ra_ff <= ra_in;
         pend_ff <= pend_in;
      end
   end

   swfd_ram #(.WIDTH(8), .DEPTH(FRAME_STORE_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (wa_ff),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_req),
      .rd_addr (ra_ff),
      .rd_data (stat.rd_data)
   );

   swfd_ram #(.WIDTH(1), .DEPTH(FRAME_STORE_DEPTH)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_addr),
      .wr_data (mark_wdata),
      .rd_en   (cmd.rd_req),
      .rd_addr (ra_ff),
      .rd_data (stat.rd_end)
   );

   assign stat.empty = (pend_ff == '0);
endmodule

[hw/rtl/sync_word_frame_deframer_crc16.sv]
// Sync-word deframer with CRC-16/X-25 check; top level.
// A transferred byte is written to the store, read in SQ_RUN and parsed in SQ_EXEC; results follow in order.
// A new input transfer is taken only in SQ_IDLE, once the stored bytes are parsed or the result count exceeds
// MAX_RESULTS - 2; a truncated verdict after a payload result and rsp stalls delay it further.
// Reset: synchronous; clears pointers, parser phase, CRC, counters and header layout.
// Depends on swfd_pkg, swfd_if, swfd_store.
module sync_word_frame_deframer_crc16 import swfd_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   swfd_req_if.sink   req_if,
   swfd_rsp_if.source rsp_if,
   input  logic  csr_write_enable,
   input  logic  csr_write_data
);
   seq_type          seq_ff, seq_in;
   phase_type        phase_ff, phase_in;
   logic [FP_W-1:0]  fp_ff, fp_in;
   logic [15:0]      crc_ff, crc_in;
   logic [6:0]       hid_ff, hid_in;
   logic [10:0]      hlen_ff, hlen_in;
   logic [31:0]      good_ff, good_in, bad_ff, bad_in;
   logic [7:0]       first_ff, first_in, crclo_ff, crclo_in;
   logic [NRES_W-1:0] nres_ff, nres_in;
   logic             layout_ff;

   logic             out_valid_ff, out_valid_in;
   kind_type         o_kind_ff, o_kind_in;
   logic [6:0]       o_id_ff, o_id_in;
   logic [10:0]      o_len_ff, o_len_in, o_idx_ff, o_idx_in;
   logic [7:0]       o_byte_ff, o_byte_in;
   logic [15:0]      o_rx_ff, o_rx_in, o_calc_ff, o_calc_in;
   logic [31:0]      o_good_ff, o_good_in, o_bad_ff, o_bad_in;
   logic             o_last_ff, o_last_in;

   store_cmd_type    cmd;
   store_stat_type   stat;
   logic             out_free, in_frame, accept;
   logic             emit, trunc, rewound;
   kind_type         e_kind;
   logic [7:0]       d, e_byte;
   logic [10:0]      e_idx;
   logic [15:0]      e_rx, e_calc;
   logic [FP_W-1:0]  fp_inc;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign in_frame = (phase_ff != PH_HUNT) && (phase_ff != PH_SYNC2);
   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (seq_ff == SQ_IDLE);
   assign d = stat.rd_data;
   assign fp_inc = fp_ff + 1'b1;

   always_comb begin
      seq_in = seq_ff;
      phase_in = phase_ff;
      fp_in = fp_ff;
      crc_in = crc_ff;
      hid_in = hid_ff;
      hlen_in = hlen_ff;
      good_in = good_ff;
      bad_in = bad_ff;
      first_in = first_ff;
      crclo_in = crclo_ff;
      nres_in = nres_ff;
      emit = 1'b0;
      trunc = 1'b0;
      rewound = 1'b0;
      e_kind = KIND_PAYLOAD;
      e_byte = '0;
      e_idx = '0;
      e_rx = '0;
      e_calc = '0;
      cmd = '0;
      cmd.wr_data = req_if.data_byte;
      cmd.wr_eos = req_if.end_of_stream;
      cmd.retained = in_frame ? fp_ff : '0;

      case (seq_ff)
         SQ_IDLE: begin
            if (accept) begin
               cmd.wr_req = 1'b1;
               nres_in = '0;
               seq_in = SQ_RUN;
            end
         end
         SQ_RUN: begin
            if (stat.empty || nres_ff > NRES_W'(MAX_RESULTS - 2)) begin
               seq_in = SQ_IDLE;
            end else begin
               cmd.rd_req = 1'b1;
               seq_in = SQ_EXEC;
            end
         end
         SQ_EXEC: begin
            if (out_free) begin
               case (phase_ff)
                  PH_HUNT: begin
                     if (d == SYNC_FIRST) phase_in = PH_SYNC2;
                  end
                  PH_SYNC2: begin
                     if (d == SYNC_SECOND) begin
                        phase_in = PH_HDR0;
                        fp_in = '0;
                        crc_in = CRC_INIT;
                     end else if (d != SYNC_FIRST) begin
                        phase_in = PH_HUNT;
                     end
                  end
                  PH_HDR0: begin
                     first_in = d;
                     fp_in = FP_W'(1);
                     phase_in = PH_HDR1;
                  end
                  PH_HDR1: begin
                     if (layout_ff) begin
                        hid_in = first_ff[6:0];
                        hlen_in = {2'b00, first_ff[7], d};
                     end else begin
                        hid_in = {2'b00, first_ff[4:0]};
                        hlen_in = {first_ff[7:5], d};
                     end
                     fp_in = FP_W'(2);
                     phase_in = (hlen_in != '0) ? PH_PAYLOAD : PH_CRC0;
                  end
                  PH_PAYLOAD: begin
                     emit = 1'b1;
                     e_kind = KIND_PAYLOAD;
                     e_byte = d;
                     e_idx = 11'(fp_ff - FP_W'(2));
                     crc_in = crc_byte(crc_ff, d);
                     fp_in = fp_inc;
                     if (fp_ff - 1'b1 >= FP_W'(hlen_ff)) phase_in = PH_CRC0;
                  end
                  PH_CRC0: begin
                     crclo_in = d;
                     fp_in = fp_inc;
                     phase_in = PH_CRC1;
                  end
                  PH_CRC1: begin
                     emit = 1'b1;
                     e_rx = {d, crclo_ff};
                     e_calc = ~crc_ff;
                     if (e_rx == e_calc) begin
                        good_in = (&good_ff) ? good_ff : good_ff + 1'b1;
                        e_kind = KIND_GOOD;
                     end else begin
                        bad_in = (&bad_ff) ? bad_ff : bad_ff + 1'b1;
                        e_kind = KIND_CRC_ERR;
                        rewound = 1'b1;
                        cmd.rewind = 1'b1;
                        cmd.rewind_len = fp_inc;
                     end
                     phase_in = PH_HUNT;
                     fp_in = '0;
                     crc_in = CRC_INIT;
                  end
                  default: begin
                     phase_in = PH_HUNT;
                  end
               endcase
               if (stat.rd_end && !rewound) begin
                  trunc = (phase_in != PH_HUNT) && (phase_in != PH_SYNC2)
                          && (fp_in >= FP_W'(3));
                  phase_in = PH_HUNT;
                  fp_in = '0;
                  crc_in = CRC_INIT;
               end
               if (emit) nres_in = nres_ff + 1'b1;
               if (trunc && emit) begin
                  seq_in = SQ_TRUNC;
               end else begin
                  if (trunc) begin
                     emit = 1'b1;
                     e_kind = KIND_TRUNC;
                     nres_in = nres_ff + 1'b1;
                  end
                  seq_in = SQ_RUN;
               end
            end
         end
         SQ_TRUNC: begin
            if (out_free) begin
               emit = 1'b1;
               e_kind = KIND_TRUNC;
               nres_in = nres_ff + 1'b1;
               seq_in = SQ_RUN;
            end
         end
         default: begin
            seq_in = SQ_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_if.ready;
      o_kind_in = o_kind_ff;
      o_id_in = o_id_ff;
      o_len_in = o_len_ff;
      o_byte_in = o_byte_ff;
      o_idx_in = o_idx_ff;
      o_rx_in = o_rx_ff;
      o_calc_in = o_calc_ff;
      o_good_in = o_good_ff;
      o_bad_in = o_bad_ff;
      o_last_in = o_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         o_kind_in = e_kind;
         o_id_in = hid_ff;
         o_len_in = hlen_ff;
         o_byte_in = e_byte;
         o_idx_in = e_idx;
         o_rx_in = e_rx;
         o_calc_in = e_calc;
         o_good_in = good_in;
         o_bad_in = bad_in;
         o_last_in = (e_kind != KIND_PAYLOAD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SQ_IDLE;
         phase_ff <= PH_HUNT;
         fp_ff <= '0;
         crc_ff <= CRC_INIT;
         hid_ff <= '0;
         hlen_ff <= '0;
         good_ff <= '0;
         bad_ff <= '0;
         first_ff <= '0;
         crclo_ff <= '0;
         nres_ff <= '0;
         layout_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         phase_ff <= phase_in;
         fp_ff <= fp_in;
         crc_ff <= crc_in;
         hid_ff <= hid_in;
         hlen_ff <= hlen_in;
         good_ff <= good_in;
         bad_ff <= bad_in;
         first_ff <= first_in;
         crclo_ff <= crclo_in;
         nres_ff <= nres_in;
         if (csr_write_enable) layout_ff <= csr_write_data;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      o_kind_ff <= o_kind_in;
      o_id_ff <= o_id_in;
      o_len_ff <= o_len_in;
      o_byte_ff <= o_byte_in;
      o_idx_ff <= o_idx_in;
      o_rx_ff <= o_rx_in;
      o_calc_ff <= o_calc_in;
      o_good_ff <= o_good_in;
      o_bad_ff <= o_bad_in;
      o_last_ff <= o_last_in;
   end

   swfd_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.kind = o_kind_ff;
   assign rsp_if.frame_id = o_id_ff;
   assign rsp_if.payload_length = o_len_ff;
   assign rsp_if.payload_byte = o_byte_ff;
   assign rsp_if.byte_index = o_idx_ff;
   assign rsp_if.crc_received = o_rx_ff;
   assign rsp_if.crc_computed = o_calc_ff;
   assign rsp_if.valid_total = o_good_ff;
   assign rsp_if.error_total = o_bad_ff;
   assign rsp_if.last = o_last_ff;
endmodule

[hw/rtl/swfd_check.sv]
// Port-level checker for the deframer, bound to the top level.
// Depends on swfd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module swfd_check import swfd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input kind_type    rsp_kind,
   input logic [15:0] rsp_crc_received,
   input logic [15:0] rsp_crc_computed,
   input logic        rsp_last
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLY(a_last_on_verdict, clock, reset, rsp_valid,
                 rsp_last == (rsp_kind != KIND_PAYLOAD))
   `ASSERT_IMPLY(a_good_crc_match, clock, reset, rsp_valid && rsp_kind == KIND_GOOD,
                 rsp_crc_received == rsp_crc_computed)
   `ASSERT_IMPLY(a_bad_crc_differs, clock, reset,
                 rsp_valid && rsp_kind == KIND_CRC_ERR,
                 rsp_crc_received != rsp_crc_computed)
endmodule

bind sync_word_frame_deframer_crc16 swfd_check u_swfd_check (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_kind         (rsp_if.kind),
   .rsp_crc_received (rsp_if.crc_received),
   .rsp_crc_computed (rsp_if.crc_computed),
   .rsp_last         (rsp_if.last)
);
